// File: hw/rtl/smau_pkg.sv
// Shared codes for the small matrix arithmetic unit.
// Used by the top level and the port checker; no dependencies.
`timescale 1ns / 1ps
package smau_pkg;
	localparam int DATA_W = 32;
	localparam int IDX_W = 3;
	localparam int OP_W = 3;
	localparam int SIZE_W = 4;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int TDATA_W = 40;

	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL = 3'd2;
	localparam logic [OP_W-1:0] OP_TRANS = 3'd3;
	localparam logic [OP_W-1:0] OP_DET = 3'd4;

	localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd1;
endpackage

// File: hw/rtl/smau_store.sv
// Matrix element store: one write port, one registered read port.
// Per-entry written flags make never-written entries read as zero. No dependencies.
`timescale 1ns / 1ps
module smau_store #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);
	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [31:0]      data_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : 32'd0;
endmodule

// File: hw/rtl/small_matrix_arith_unit.sv
// Small matrix arithmetic unit: element loads, then add/sub/mul/transpose/determinant.
// Depends on smau_pkg and smau_store.
// Loads: one per cycle while idle, no result. Add/sub/transpose: read, data and output states per element.
// Multiply: one shared 32x32 multiplier; each term passes through read, data and accumulate states.
// Determinant: clear partial sums, check each column set, add a term per unused column of
// a nonzero set, then read and emit the final sum. Output stalls hold the sequencer.
// Reset (arst_n low, async) clears the stores, operation to add and size to 1.
`timescale 1ns / 1ps
module small_matrix_arith_unit #(
	parameter int MAX_DIM = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [smau_pkg::TDATA_W-1:0]    s_tdata,   // row_index, col_index, value
	input  logic [smau_pkg::KIND_W-1:0]     s_tuser,   // kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [smau_pkg::TDATA_W-1:0]    m_tdata,   // out_row, out_col, out_value
	output logic                            m_tlast,   // last
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [smau_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smau_pkg::SIZE_W-1:0]     cfg_data
);
	import smau_pkg::*;

	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CW = $clog2(MAX_DIM + 1);
	localparam int MW = MAX_DIM;
	localparam int PD = 1 << MAX_DIM;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EL_RD, ST_EL_DAT, ST_MUL_ACC, ST_EL_OUT,
		ST_CLR, ST_DM_RD, ST_DM_CHK, ST_DC, ST_DMUL, ST_DACC, ST_DF_RD, ST_DOUT
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [SIZE_W-1:0]   size_q;
	logic [CW-1:0]       n_q, i_q, j_q, k_q, c_q;
	logic [MW-1:0]       m_q, full_q;
	logic [31:0]         p_q, prod_q, acc_q, pr_q;
	logic [31:0]         partial [PD];
	logic                out_valid_q, out_last_q;
	logic [IDX_W-1:0]    out_row_q, out_col_q;
	logic [31:0]         out_value_q;

	logic [IDX_W-1:0]    in_row, in_col;
	logic [31:0]         in_value;
	logic                load_ok, load_a, load_b;
	logic [AW-1:0]       load_addr;
	logic [CW-1:0]       n_eff, n_last, row_r;
	logic [MW:0]         full_w;
	logic [MW-1:0]       bit_m, m_next;
	logic                bit_used, flip;
	logic [AW-1:0]       a_addr, b_addr;
	logic                a_en, b_en;
	logic [31:0]         a_rd, b_rd, mul_x, prod_w;
	logic                out_free;
	logic                out_load;

	assign in_row = s_tdata[2:0];
	assign in_col = s_tdata[5:3];
	assign in_value = s_tdata[37:6];
	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign load_ok = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
	assign load_addr = AW'(int'(in_row) * MAX_DIM + int'(in_col));
	assign load_a = s_tvalid && s_tready && (s_tuser == KIND_LOAD_A) && load_ok;
	assign load_b = s_tvalid && s_tready && (s_tuser == KIND_LOAD_B) && load_ok;

	always_comb begin
		if (size_q == '0) begin
			n_eff = CW'(1);
		end else if (int'(size_q) > MAX_DIM) begin
			n_eff = CW'(MAX_DIM);
		end else begin
			n_eff = CW'(size_q);
		end
	end
	assign full_w = ((MW + 1)'(1) << n_eff) - (MW + 1)'(1);
	assign n_last = n_q - CW'(1);

	// Row of the determinant expansion equals the number of columns already used.
	always_comb begin
		row_r = '0;
		for (int b = 0; b < MW; b++) begin
			row_r = row_r + CW'(m_q[b]);
		end
	end
	assign bit_m = MW'(1) << c_q;
	assign bit_used = (m_q & bit_m) != '0;
	assign m_next = m_q + MW'(1);
	// Sign flips with the parity of used columns above this one.
	always_comb begin
		flip = 1'b0;
		for (int b = 0; b < MW; b++) begin
			if (b > int'(c_q)) begin
				flip = flip ^ m_q[b];
			end
		end
	end

	always_comb begin
		a_en = 1'b0;
		b_en = 1'b0;
		a_addr = AW'(int'(i_q) * MAX_DIM + int'(j_q));
		b_addr = AW'(int'(i_q) * MAX_DIM + int'(j_q));
		case (state_q)
			ST_EL_RD: begin
				a_en = 1'b1;
				b_en = 1'b1;
				if (op_q == OP_TRANS) begin
					a_addr = AW'(int'(j_q) * MAX_DIM + int'(i_q));
				end else if (op_q == OP_MUL) begin
					a_addr = AW'(int'(i_q) * MAX_DIM + int'(k_q));
					b_addr = AW'(int'(k_q) * MAX_DIM + int'(j_q));
				end
			end
			ST_DC: begin
				a_en = (c_q != n_q) && !bit_used;
				a_addr = AW'(int'(row_r) * MAX_DIM + int'(c_q));
			end
			default: begin
			end
		endcase
	end

	smau_store #(.DEPTH(CELLS), .AW(AW)) u_store_a (
		.clk(clk), .arst_n(arst_n), .wr_en(load_a), .wr_addr(load_addr), .wr_data(in_value),
		.rd_en(a_en), .rd_addr(a_addr), .rd_data(a_rd)
	);
	smau_store #(.DEPTH(CELLS), .AW(AW)) u_store_b (
		.clk(clk), .arst_n(arst_n), .wr_en(load_b), .wr_addr(load_addr), .wr_data(in_value),
		.rd_en(b_en), .rd_addr(b_addr), .rd_data(b_rd)
	);

	// Shared multiplier: expansion terms and dot-product terms.
	assign mul_x = (state_q == ST_DMUL) ? p_q : b_rd;
	assign prod_w = a_rd * mul_x;

	// Expansion partial sums
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			partial[m_q] <= (m_q == '0) ? 32'd1 : 32'd0;
		end else if (state_q == ST_DACC) begin
			partial[m_q | bit_m] <= flip ? (pr_q - prod_q) : (pr_q + prod_q);
		end
		if (state_q == ST_DM_RD || state_q == ST_DF_RD) begin
			pr_q <= partial[m_q];
		end else if (state_q == ST_DC) begin
			pr_q <= partial[m_q | bit_m];
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign out_load = out_free && (state_q == ST_EL_OUT || state_q == ST_DOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_ADD;
			size_q <= SIZE_W'(1);
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			c_q <= '0;
			m_q <= '0;
			full_q <= '0;
			p_q <= '0;
			prod_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
			out_row_q <= '0;
			out_col_q <= '0;
			out_value_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_OPERATION) begin
					op_q <= cfg_data[OP_W-1:0];
				end else if (cfg_index == REG_SIZE) begin
					size_q <= cfg_data;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tuser == KIND_START) begin
						n_q <= n_eff;
						full_q <= full_w[MW-1:0];
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						m_q <= '0;
						acc_q <= '0;
						if (op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL ||
						    op_q == OP_TRANS) begin
							state_q <= ST_EL_RD;
						end else if (op_q == OP_DET) begin
							state_q <= ST_CLR;
						end
					end
				end
				ST_EL_RD: state_q <= ST_EL_DAT;
				ST_EL_DAT: begin
					if (op_q == OP_MUL) begin
						prod_q <= prod_w;
						state_q <= ST_MUL_ACC;
					end else begin
						if (op_q == OP_ADD) begin
							acc_q <= a_rd + b_rd;
						end else if (op_q == OP_SUB) begin
							acc_q <= a_rd - b_rd;
						end else begin
							acc_q <= a_rd;
						end
						state_q <= ST_EL_OUT;
					end
				end
				ST_MUL_ACC: begin
					acc_q <= acc_q + prod_q;
					k_q <= k_q + CW'(1);
					state_q <= (k_q == n_last) ? ST_EL_OUT : ST_EL_RD;
				end
				ST_EL_OUT: begin
					if (out_free) begin
						out_row_q <= IDX_W'(i_q);
						out_col_q <= IDX_W'(j_q);
						out_value_q <= acc_q;
						out_last_q <= (i_q == n_last) && (j_q == n_last);
						acc_q <= '0;
						k_q <= '0;
						if (j_q == n_last) begin
							j_q <= '0;
							i_q <= i_q + CW'(1);
						end else begin
							j_q <= j_q + CW'(1);
						end
						state_q <= ((i_q == n_last) && (j_q == n_last)) ? ST_IDLE : ST_EL_RD;
					end
				end
				ST_CLR: begin
					if (m_q == full_q) begin
						m_q <= '0;
						state_q <= ST_DM_RD;
					end else begin
						m_q <= m_next;
					end
				end
				ST_DM_RD: state_q <= ST_DM_CHK;
				ST_DM_CHK: begin
					p_q <= pr_q;
					c_q <= '0;
					if (pr_q == '0) begin
						m_q <= m_next;
						state_q <= (m_next == full_q) ? ST_DF_RD : ST_DM_RD;
					end else begin
						state_q <= ST_DC;
					end
				end
				ST_DC: begin
					if (c_q == n_q) begin
						m_q <= m_next;
						state_q <= (m_next == full_q) ? ST_DF_RD : ST_DM_RD;
					end else if (bit_used) begin
						c_q <= c_q + CW'(1);
					end else begin
						state_q <= ST_DMUL;
					end
				end
				ST_DMUL: begin
					prod_q <= prod_w;
					state_q <= ST_DACC;
				end
				ST_DACC: begin
					c_q <= c_q + CW'(1);
					state_q <= ST_DC;
				end
				ST_DF_RD: state_q <= ST_DOUT;
				ST_DOUT: begin
					if (out_free) begin
						out_row_q <= '0;
						out_col_q <= '0;
						out_value_q <= pr_q;
						out_last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {2'b00, out_value_q, out_col_q, out_row_q};
endmodule

// File: hw/rtl/smau_checker.sv
// Port-level checks for the small matrix arithmetic unit, bound to the top level.
// Depends on smau_pkg.
`timescale 1ns / 1ps
module smau_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [smau_pkg::KIND_W-1:0]    s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [smau_pkg::TDATA_W-1:0]   m_tdata,
	input logic                           m_tlast
);
	import smau_pkg::*;

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result dropped or changed under stall");

	// A load transfer leaves the block ready for the next item.
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == KIND_LOAD_A || s_tuser == KIND_LOAD_B)
		|=> s_tready)
		else $error("load stalled the input");

	// A mid-run result on the output means the block is still busy.
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input accepted before run finished");

	// A start transfer never pops out a result in the next cycle from nowhere.
	a_start_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_START && !m_tvalid |=> !m_tvalid)
		else $error("result appeared without compute cycles");
endmodule

bind small_matrix_arith_unit smau_checker u_smau_checker (.*);

// File: verif/tb_small_matrix_arith_unit.sv
// Self-checking testbench for small_matrix_arith_unit: directed table, then random phases.
// Covers element loads, every operation and size clamping, scored against an in-bench predictor.
// Depends on smau_pkg and the RTL of the unit; nothing else.
`timescale 1ns / 1ps
module tb_small_matrix_arith_unit;
	import smau_pkg::*;

	localparam int DIM = 8;
	localparam logic [OP_W-1:0] OP_BAD = 3'd5;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] val;
		logic              last;
	} elem_t;

	typedef struct {
		bit                cfg;
		logic [1:0]        sel;    // register index or kind
		logic [3:0]        data;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] val;
		bit                typed;
		logic [DATA_W-1:0] ev;
	} row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
	logic [TDATA_W-1:0] s_tdata, m_tdata;
	logic [KIND_W-1:0] s_tuser;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0] cfg_data;

	small_matrix_arith_unit #(.MAX_DIM(DIM)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [DATA_W-1:0] mat_a [DIM*DIM];
	logic [DATA_W-1:0] mat_b [DIM*DIM];
	logic [OP_W-1:0]   cur_op;
	logic [SIZE_W-1:0] cur_size;
	elem_t             pending_elems[$];
	int                errors;
	int                mode;
	int                hold_req_cnt;
	int                items_sent;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100000000;
		$display("[small_matrix_arith_unit] ERROR");
		$finish;
	end

	function automatic logic [DATA_W-1:0] det_of(int n);
		logic [DATA_W-1:0] part [256];
		logic [DATA_W-1:0] term;
		int r, full, hi;
		for (int m = 0; m < 256; m++) part[m] = '0;
		part[0] = 1;
		full = (1 << n) - 1;
		for (int m = 0; m < full; m++) begin
			if (part[m] == 0) continue;
			r = $countones(m);
			for (int c = 0; c < n; c++) begin
				if (((m >> c) & 1) != 0) continue;
				term = mat_a[r*DIM + c] * part[m];
				// sign follows the used columns to the right of c
				hi = m & ~((2 << c) - 1);
				if (($countones(hi) & 1) != 0)
					part[m | (1 << c)] = part[m | (1 << c)] - term;
				else
					part[m | (1 << c)] = part[m | (1 << c)] + term;
			end
		end
		return part[full];
	endfunction

	task automatic predict_item(input logic [1:0] k, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
		int n;
		logic [DATA_W-1:0] acc;
		elem_t e;
		if (k == KIND_LOAD_A) mat_a[r*DIM + c] = v;
		else if (k == KIND_LOAD_B) mat_b[r*DIM + c] = v;
		else if (k == KIND_START) begin
			n = (cur_size == 0) ? 1 : ((cur_size > DIM) ? DIM : cur_size);
			if (cur_op == OP_DET) begin
				e = '{row: '0, col: '0, val: det_of(n), last: 1'b1};
				pending_elems.push_back(e);
			end else if (cur_op <= OP_TRANS) begin
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++) begin
						case (cur_op)
							OP_ADD: acc = mat_a[i*DIM + j] + mat_b[i*DIM + j];
							OP_SUB: acc = mat_a[i*DIM + j] - mat_b[i*DIM + j];
							OP_MUL: begin
								acc = '0;
								for (int q = 0; q < n; q++)
									acc = acc + mat_a[i*DIM + q] * mat_b[q*DIM + j];
							end
							default: acc = mat_a[j*DIM + i];
						endcase
						e = '{row: i[IDX_W-1:0], col: j[IDX_W-1:0], val: acc,
							last: (i == n-1 && j == n-1)};
						pending_elems.push_back(e);
					end
			end
		end
	endtask

	task automatic send_item(input logic [1:0] k, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
		int gap, pct;
		pct = (mode == 1) ? 60 : ((mode == 3) ? 9 : 0);
		gap = 0;
		while ($urandom_range(99) < pct && gap < 40) gap++;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {2'b00, v, c, r};
		do @(posedge clk); while (!s_tready);
		predict_item(k, r, c, v);
		if (k != KIND_NONE) items_sent++;
	endtask

	// hold the input quiet, drain all results, then write one register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] d);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_elems.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_OPERATION) cur_op = d[OP_W-1:0];
		else if (idx == REG_SIZE) cur_size = d;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int hold_seen, hold_left, pct;
		hold_seen = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			pct = (mode == 2) ? 60 : ((mode == 3) ? 9 : 0);
			if (hold_seen != hold_req_cnt) begin
				hold_seen = hold_req_cnt;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= pct);
			end
		end
	end

	always @(posedge clk) begin
		elem_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_elems.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: row %0d col %0d value %h last %b",
						m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tlast);
			end else begin
				want = pending_elems.pop_front();
				if (m_tdata[2:0] !== want.row || m_tdata[5:3] !== want.col ||
						m_tdata[37:6] !== want.val || m_tlast !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %0d,%0d %h last %b, got %0d,%0d %h last %b",
							want.row, want.col, want.val, want.last,
							m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tlast);
				end
			end
		end
	end

	function automatic row_t ld(logic [1:0] k, int r, int c, logic [DATA_W-1:0] v);
		return '{cfg: 0, sel: k, data: '0, row: r[2:0], col: c[2:0], val: v, typed: 0, ev: '0};
	endfunction

	function automatic row_t cf(logic [1:0] idx, logic [3:0] d);
		return '{cfg: 1, sel: idx, data: d, row: '0, col: '0, val: '0, typed: 0, ev: '0};
	endfunction

	function automatic row_t st(bit typed, logic [DATA_W-1:0] ev);
		return '{cfg: 0, sel: KIND_START, data: '0, row: '0, col: '0, val: '0,
			typed: typed, ev: ev};
	endfunction

	initial begin
		row_t dir_rows[$];
		row_t dr;
		int n, op, sz, rounds, loads, u, r, c;
		logic [1:0] k;
		logic [DATA_W-1:0] v;
		elem_t e;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		mode = 0;
		hold_req_cnt = 0;
		items_sent = 0;
		for (int i = 0; i < DIM*DIM; i++) begin
			mat_a[i] = '0;
			mat_b[i] = '0;
		end
		cur_op = OP_ADD;
		cur_size = 1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir_rows = '{
			st(1, 32'h0),
			ld(KIND_LOAD_A, 0, 0, 32'h7FFF_FFFF), ld(KIND_LOAD_B, 0, 0, 32'h1),
			st(1, 32'h8000_0000),
			cf(REG_OPERATION, OP_SUB),
			ld(KIND_LOAD_A, 7, 7, 32'h8000_0000), ld(KIND_LOAD_B, 0, 0, 32'hFFFF_FFFF),
			st(1, 32'h8000_0000),
			cf(REG_SIZE, 4'd0), st(1, 32'h8000_0000),
			cf(REG_SPARE, 4'd3), cf(2'd3, 4'd5), st(1, 32'h8000_0000),
			cf(REG_OPERATION, OP_DET), cf(REG_SIZE, 4'd15), st(1, 32'h0),
			cf(REG_OPERATION, OP_BAD), st(0, 0), ld(KIND_NONE, 1, 1, 32'h5555_5555),
			cf(REG_OPERATION, OP_MUL), cf(REG_SIZE, 4'd2),
			ld(KIND_LOAD_A, 0, 1, 32'h3), ld(KIND_LOAD_B, 1, 0, 32'h8000_0000), st(0, 0),
			cf(REG_OPERATION, OP_TRANS), st(0, 0),
			cf(REG_OPERATION, OP_DET), st(0, 0),
			cf(REG_OPERATION, OP_ADD), cf(REG_SIZE, 4'd8), st(0, 0)
		};
		foreach (dir_rows[i]) begin
			dr = dir_rows[i];
			if (dr.cfg) write_reg(dr.sel, dr.data);
			else begin
				send_item(dr.sel, dr.row, dr.col, dr.val);
				// typed rows carry a single known result
				if (dr.typed) begin
					e = pending_elems.pop_back();
					e.val = dr.ev;
					pending_elems.push_back(e);
				end
			end
		end

		items_sent = 0;
		for (int ph = 0; items_sent < 450; ph++) begin
			u = $urandom_range(19);
			op = (u < 18) ? (u % 5) : (OP_BAD + $urandom_range(2));
			u = $urandom_range(9);
			if (u < 7) sz = $urandom_range(1, 4);
			else if (u == 7) sz = $urandom_range(5, 8);
			else if (u == 8) sz = 0;
			else sz = $urandom_range(9, 15);
			n = (sz == 0) ? 1 : ((sz > DIM) ? DIM : sz);
			if (op == OP_DET && n > 5) begin
				sz = $urandom_range(1, 5);
				n = sz;
			end
			if (ph == 1) begin
				op = OP_ADD;
				sz = 8;
				n = 8;
			end
			mode = 0;
			if ($urandom_range(1)) begin
				write_reg(REG_OPERATION, op[3:0]);
				write_reg(REG_SIZE, sz[3:0]);
			end else begin
				write_reg(REG_SIZE, sz[3:0]);
				write_reg(REG_OPERATION, op[3:0]);
			end
			mode = ph % 4;
			if (ph == 1) begin
				// stall the output while starts keep coming
				hold_req_cnt++;
				repeat (3) send_item(KIND_START, '0, '0, '0);
				continue;
			end
			rounds = $urandom_range(1, 3);
			for (int rd = 0; rd < rounds; rd++) begin
				loads = $urandom_range(0, (2*n*n > 40) ? 40 : 2*n*n);
				for (int l = 0; l < loads; l++) begin
					u = $urandom_range(99);
					k = (u < 5) ? KIND_NONE : ((u < 52) ? KIND_LOAD_A : KIND_LOAD_B);
					if ($urandom_range(99) < 85) begin
						r = $urandom_range(n-1);
						c = $urandom_range(n-1);
					end else begin
						r = $urandom_range(DIM-1);
						c = $urandom_range(DIM-1);
					end
					case ($urandom_range(19))
						0: v = 32'h8000_0000;
						1: v = 32'h7FFF_FFFF;
						2: v = 32'hFFFF_FFFF;
						3: v = 32'h0;
						4: v = $urandom_range(7) - 3;
						default: v = $urandom;
					endcase
					send_item(k, r[2:0], c[2:0], v);
				end
				send_item(($urandom_range(19) == 0) ? KIND_NONE : KIND_START,
					3'($urandom), 3'($urandom), $urandom);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_elems.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (errors == 0)
			$display("[small_matrix_arith_unit] OK");
		else
			$display("[small_matrix_arith_unit] ERROR");
		$finish;
	end
endmodule
